### rtl/eia_pkg.sv
// ----------------------------------------------------------------------------
// Event interrupt aggregator package
// Shared operation codes, transaction types and line acceptance levels.
// ----------------------------------------------------------------------------
package eia_pkg;

   typedef enum logic [2:0] {
      FUNC_ADD_EVENT  = 3'd0,
      FUNC_ADD_EXT    = 3'd1,
      FUNC_REMOVE_EXT = 3'd2,
      FUNC_ACK        = 3'd3,
      FUNC_SERVICE    = 3'd4,
      FUNC_RAISE      = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      CSR_MASK6_NORM = 3'd0,
      CSR_MASK4_NORM = 3'd1,
      CSR_MASK2_NORM = 3'd2,
      CSR_MASK6_EXT  = 3'd3,
      CSR_MASK4_EXT  = 3'd4,
      CSR_MASK2_EXT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      LINE_NONE = 2'd0,
      LINE_LVL6 = 2'd1,
      LINE_LVL4 = 2'd2,
      LINE_LVL2 = 2'd3
   } line_type;

   localparam logic [3:0] LVL6_ACCEPT = 4'h5;
   localparam logic [3:0] LVL4_ACCEPT = 4'h3;
   localparam logic [3:0] LVL2_ACCEPT = 4'h1;
   localparam logic [3:0] IMASK_ALL   = 4'hf;

   // Classified transaction passed from the front end to the back end
   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] bits;
      logic [63:0] expiry;
      logic        delay_nz;
      logic [63:0] now;
      logic        acc6;
      logic        acc4;
      logic        acc2;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_OUT
   } state_type;

endpackage

### rtl/asic_event_interrupt_aggregator.sv
// ----------------------------------------------------------------------------
// Event interrupt aggregator
// Folds normal and external event bits into three priority lines.
// ----------------------------------------------------------------------------
// The back end handles one transaction at a time. Add-with-delay and service
// (with delays pending) walk all DELAY_SLOTS slots, one slot per cycle through a
// single comparator. Other operations skip the walk. A request is registered
// in the front end, then held in the queue, then taken into the back end,
// which runs a finish step and registers the response. The next request can
// be accepted in the cycle after the previous one enters the queue. Response
// is registered and waits for rsp_ready. Mask registers are written through
// the csr_ port; the user must do so only while no transaction is in flight,
// which the block itself does not enforce.
module asic_event_interrupt_aggregator
   import eia_pkg::*;
#(
   parameter int DELAY_SLOTS     = 16,
   parameter int CYCLES_PER_UNIT = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_event_bits,
   input  logic [15:0] req_delay_units,
   input  logic [63:0] req_now_cycles,
   input  logic        req_cpu_block_bit,
   input  logic        req_vector_base_zero,
   input  logic [3:0]  req_cpu_int_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_delivered,
   output logic [1:0]  rsp_line_taken,
   output logic        rsp_from_external,
   output logic [31:0] rsp_status_normal_out,
   output logic [31:0] rsp_status_ext_out,
   output logic [31:0] rsp_unrouted_bits,
   output logic        rsp_anything_pending,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type f_cmd, q_cmd;
   logic    f_valid, f_ready, q_valid, q_ready;

   assign csr_ready = 1'b1;

   eia_front #(.CYCLES_PER_UNIT(CYCLES_PER_UNIT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_event_bits,
      .req_delay_units, .req_now_cycles, .req_cpu_block_bit,
      .req_vector_base_zero, .req_cpu_int_mask,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   eia_fifo u_fifo (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   eia_back #(.DELAY_SLOTS(DELAY_SLOTS)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .csr_valid, .csr_index, .csr_wdata, .rsp_valid, .rsp_ready,
      .rsp_delivered, .rsp_line_taken, .rsp_from_external,
      .rsp_status_normal_out, .rsp_status_ext_out, .rsp_unrouted_bits,
      .rsp_anything_pending
   );

endmodule

### rtl/eia_front.sv
// ----------------------------------------------------------------------------
// Event interrupt aggregator front end
// Takes request transactions, computes the expiry time (span registered, then
// added) and the processor acceptance per line, and hands a command to the queue.
// ----------------------------------------------------------------------------
module eia_front
   import eia_pkg::*;
#(
   parameter int CYCLES_PER_UNIT = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_event_bits,
   input  logic [15:0] req_delay_units,
   input  logic [63:0] req_now_cycles,
   input  logic        req_cpu_block_bit,
   input  logic        req_vector_base_zero,
   input  logic [3:0]  req_cpu_int_mask,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   logic        busy_ff, busy_in;
   cmd_type     hold_ff, hold_in;
   logic [31:0] span_ff, span_in;
   logic        ok;
   logic [64:0] sum;

   function automatic logic accepts(logic [3:0] level);
      return ok && (req_cpu_int_mask != IMASK_ALL) && (req_cpu_int_mask <= level);
   endfunction

   assign ok        = !req_cpu_block_bit && !req_vector_base_zero;
   assign req_ready = !busy_ff;
   assign sum       = {1'b0, hold_ff.now} + {33'd0, span_ff};
   assign cmd_valid = busy_ff;

   // Saturating add of the registered span to the held request time
   always_comb begin
      cmd        = hold_ff;
      cmd.expiry = sum[64] ? '1 : sum[63:0];
   end

   // Capture and hold one transaction until the queue takes it
   always_comb begin
      busy_in = busy_ff;
      hold_in = hold_ff;
      span_in = span_ff;
      if (req_valid && req_ready) begin
         busy_in          = 1'b1;
         hold_in.func     = req_func;
         hold_in.bits     = req_event_bits;
         hold_in.expiry   = '0;
         hold_in.delay_nz = req_delay_units != '0;
         hold_in.now      = req_now_cycles;
         hold_in.acc6     = accepts(LVL6_ACCEPT);
         hold_in.acc4     = accepts(LVL4_ACCEPT);
         hold_in.acc2     = accepts(LVL2_ACCEPT);
         span_in          = 32'(req_delay_units) * 32'(CYCLES_PER_UNIT);
      end else if (cmd_valid && cmd_ready) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      hold_ff <= hold_in;
      span_ff <= span_in;
   end

endmodule

### rtl/eia_fifo.sv
// ----------------------------------------------------------------------------
// Event interrupt aggregator command queue
// Two-entry queue of classified commands between front and back end.
// ----------------------------------------------------------------------------
module eia_fifo
   import eia_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  cmd_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output cmd_type rd_data
);

   cmd_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign wr_ready = count_ff != 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rptr_ff];

   // Pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_data;
   end

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !wr_ready) else $error("queue overflow");
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("pop from empty queue");
`endif

endmodule

### rtl/eia_back.sv
// ----------------------------------------------------------------------------
// Event interrupt aggregator back end
// Holds event state and the delay slot table. Walks the slots one per cycle
// for add-with-delay (free slot search) and service (expiry), then decides
// the line and presents a registered response.
// ----------------------------------------------------------------------------
module eia_back
   import eia_pkg::*;
#(
   parameter int DELAY_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_delivered,
   output logic [1:0]  rsp_line_taken,
   output logic        rsp_from_external,
   output logic [31:0] rsp_status_normal_out,
   output logic [31:0] rsp_status_ext_out,
   output logic [31:0] rsp_unrouted_bits,
   output logic        rsp_anything_pending
);

   localparam int SW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;

   state_type   state_ff, state_in;
   cmd_type     cur_ff;
   logic [SW-1:0] idx_ff;
   logic        found_ff;
   logic [SW-1:0] free_ff;

   logic [31:0] m6n_ff, m4n_ff, m2n_ff, m6e_ff, m4e_ff, m2e_ff;
   logic [31:0] slot_ev_ff [DELAY_SLOTS];
   logic [63:0] slot_exp_ff [DELAY_SLOTS];
   logic [31:0] delayed_ff, stn_ff, ste_ff, extq_ff;

   logic [31:0] stn_n, ste_n, extq_n, delayed_n;
   logic [1:0]  line;
   logic        ext;
   logic [31:0] rdy, all_norm;
   logic        scan_last, need_scan;
   logic [31:0] ev_rd;
   logic [63:0] exp_rd;

   logic        r_del_ff, r_ext_ff, r_pend_ff;
   logic [1:0]  r_line_ff;
   logic [31:0] r_stn_ff, r_ste_ff, r_unr_ff;

   assign cmd_ready  = state_ff == ST_IDLE;
   assign scan_last  = idx_ff == SW'(DELAY_SLOTS - 1);
   assign ev_rd      = slot_ev_ff[idx_ff];
   assign exp_rd     = slot_exp_ff[idx_ff];
   assign need_scan  = (cmd.func == FUNC_SERVICE && delayed_ff != '0) ||
      (cmd.func == FUNC_ADD_EVENT && cmd.delay_nz && (delayed_ff & cmd.bits) == '0
       && cmd.bits != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (cmd_valid) state_in = need_scan ? ST_SCAN : ST_FINISH;
         ST_SCAN:   if (scan_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Finish step: state update and line decision
   always_comb begin
      stn_n     = stn_ff;
      ste_n     = ste_ff;
      extq_n    = extq_ff;
      delayed_n = delayed_ff;
      line      = LINE_NONE;
      ext       = 1'b0;
      rdy       = stn_ff & ~delayed_ff;
      case (cur_ff.func)
         FUNC_ADD_EVENT: begin
            if (!cur_ff.delay_nz) begin
               stn_n = stn_ff | cur_ff.bits;
            end else if ((delayed_ff & cur_ff.bits) == '0) begin
               if (found_ff) delayed_n = delayed_ff | cur_ff.bits;
               else          stn_n     = stn_ff | cur_ff.bits;
            end
         end
         FUNC_ADD_EXT: begin
            if ((extq_ff & cur_ff.bits) == '0) begin
               ste_n  = ste_ff | cur_ff.bits;
               extq_n = extq_ff | cur_ff.bits;
            end
         end
         FUNC_REMOVE_EXT: begin
            ste_n  = ste_ff & ~cur_ff.bits;
            extq_n = extq_ff & ~cur_ff.bits;
         end
         FUNC_ACK: stn_n = stn_ff & ~cur_ff.bits;
         FUNC_SERVICE: begin
            if ((rdy & m6n_ff) != '0 && cur_ff.acc6)      line = LINE_LVL6;
            else if ((rdy & m4n_ff) != '0 && cur_ff.acc4) line = LINE_LVL4;
            else if ((rdy & m2n_ff) != '0 && cur_ff.acc2) line = LINE_LVL2;
            else if ((extq_ff & m6e_ff) != '0 && cur_ff.acc6) begin
               extq_n = extq_ff & ~m6e_ff; line = LINE_LVL6; ext = 1'b1;
            end else if ((extq_ff & m4e_ff) != '0 && cur_ff.acc4) begin
               extq_n = extq_ff & ~m4e_ff; line = LINE_LVL4; ext = 1'b1;
            end else if ((extq_ff & m2e_ff) != '0 && cur_ff.acc2) begin
               extq_n = extq_ff & ~m2e_ff; line = LINE_LVL2; ext = 1'b1;
            end
         end
         FUNC_RAISE: begin
            stn_n = stn_ff | cur_ff.bits;
            if ((m6n_ff & cur_ff.bits) != '0 && cur_ff.acc6)      line = LINE_LVL6;
            else if ((m4n_ff & cur_ff.bits) != '0 && cur_ff.acc4) line = LINE_LVL4;
            else if ((m2n_ff & cur_ff.bits) != '0 && cur_ff.acc2) line = LINE_LVL2;
         end
         default: ;
      endcase
      all_norm = m6n_ff | m4n_ff | m2n_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         delayed_ff <= '0;
         stn_ff     <= '0;
         ste_ff     <= '0;
         extq_ff    <= '0;
         m6n_ff <= '0; m4n_ff <= '0; m2n_ff <= '0;
         m6e_ff <= '0; m4e_ff <= '0; m2e_ff <= '0;
         for (int i = 0; i < DELAY_SLOTS; i++) slot_ev_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_MASK6_NORM: m6n_ff <= csr_wdata;
               CSR_MASK4_NORM: m4n_ff <= csr_wdata;
               CSR_MASK2_NORM: m2n_ff <= csr_wdata;
               CSR_MASK6_EXT:  m6e_ff <= csr_wdata;
               CSR_MASK4_EXT:  m4e_ff <= csr_wdata;
               CSR_MASK2_EXT:  m2e_ff <= csr_wdata;
               default: ;
            endcase
         end
         // One slot per cycle: expire due slots for service (free search is in the datapath)
         if (state_ff == ST_SCAN) begin
            if (cur_ff.func == FUNC_SERVICE) begin
               if (ev_rd != '0 && cur_ff.now >= exp_rd) begin
                  stn_ff            <= stn_ff | ev_rd;
                  delayed_ff        <= delayed_ff & ~ev_rd;
                  slot_ev_ff[idx_ff] <= '0;
               end
            end
         end
         if (state_ff == ST_FINISH) begin
            stn_ff     <= stn_n;
            ste_ff     <= ste_n;
            extq_ff    <= extq_n;
            delayed_ff <= delayed_n;
            if (cur_ff.func == FUNC_ADD_EVENT && found_ff && delayed_n != delayed_ff)
               slot_ev_ff[free_ff] <= cur_ff.bits;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         cur_ff   <= cmd;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + SW'(1);
         if (cur_ff.func == FUNC_ADD_EVENT && !found_ff && ev_rd == '0) begin
            found_ff <= 1'b1;
            free_ff  <= idx_ff;
         end
      end
      if (state_ff == ST_FINISH && cur_ff.func == FUNC_ADD_EVENT && found_ff
          && delayed_n != delayed_ff)
         slot_exp_ff[free_ff] <= cur_ff.expiry;
      if (state_ff == ST_FINISH) begin
         r_del_ff  <= line != LINE_NONE;
         r_line_ff <= line;
         r_ext_ff  <= ext;
         r_stn_ff  <= stn_n;
         r_ste_ff  <= ste_n;
         r_unr_ff  <= stn_n & ~delayed_n & ~all_norm;
         r_pend_ff <= delayed_n != '0 || extq_n != '0 || (stn_n & all_norm) != '0;
      end
   end

   assign rsp_valid             = state_ff == ST_OUT;
   assign rsp_delivered         = r_del_ff;
   assign rsp_line_taken        = r_line_ff;
   assign rsp_from_external     = r_ext_ff;
   assign rsp_status_normal_out = r_stn_ff;
   assign rsp_status_ext_out    = r_ste_ff;
   assign rsp_unrouted_bits     = r_unr_ff;
   assign rsp_anything_pending  = r_pend_ff;

`ifndef SYNTHESIS
   a_ext_needs_line : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_external |-> rsp_delivered) else $error("ext without line");
   a_line_delivered : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delivered == (rsp_line_taken != LINE_NONE)))
      else $error("line and delivered disagree");
   a_scan_to_finish : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && scan_last |=> state_ff == ST_FINISH)
      else $error("scan did not finish");
`endif

endmodule
